// ===== rtl/core/xyzr_pkg.sv =====
package xyzr_pkg;

    // Default widths of the datapath.
    localparam int COORD_WIDTH_DEF    = 16;
    localparam int TRIG_FRAC_BITS_DEF = 14;

    // Configuration interface.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 9;
    localparam int ANGLE_WIDTH     = 9;
    localparam int NUM_AXES        = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_X_ENABLE = 3'd0,
        REG_Y_ENABLE = 3'd1,
        REG_Z_ENABLE = 3'd2,
        REG_X_ANGLE  = 3'd3,
        REG_Y_ANGLE  = 3'd4,
        REG_Z_ANGLE  = 3'd5
    } t_cfg_reg;

    // Axis slots in the per-axis arrays.
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // Sine table base format is Q1.30.
    localparam int          Q30_BITS = 30;
    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam int          SIN_TAB_LAST = 90;

    // Taylor series divisors (2k)*(2k+1) for k = 1..12.
    typedef logic [63:0] t_div_tab [1:12];
    localparam t_div_tab FACT_DIV = '{
        64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    typedef logic [Q30_BITS:0] t_sin_tab [0:SIN_TAB_LAST];

    // Sine of r degrees (0..90) in Q1.30, from a truncating Taylor series.
    function automatic logic [Q30_BITS:0] sin_q30(input int unsigned r);
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        logic        done;
        x    = (64'(r) * PI_Q30 + 64'd90) / 64'd180;
        term = x;
        sum  = longint'(x);
        done = 1'b0;
        for (int k = 1; k <= 12; k++) begin
            if (!done) begin
                term = ((term * x) >> Q30_BITS) * x >> Q30_BITS;
                term = term / FACT_DIV[k];
                if (term == 64'd0) begin
                    done = 1'b1;
                end else if ((k % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (longint'(1) << Q30_BITS)) begin
            sum = longint'(1) << Q30_BITS;
        end
        return (Q30_BITS + 1)'(sum);
    endfunction

    function automatic t_sin_tab build_sin_tab();
        t_sin_tab tab;
        for (int d = 0; d <= SIN_TAB_LAST; d++) begin
            tab[d] = sin_q30(d);
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_Q30_TAB = build_sin_tab();

endpackage

// ===== rtl/core/xyzr_cfg.sv =====
module xyzr_cfg
    import xyzr_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
    localparam int TW = TRIG_FRAC_BITS + 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]          i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]           i_cfg_data,
    output logic [NUM_AXES-1:0]                 o_en,
    output logic [NUM_AXES-1:0][TW-1:0]         o_sin,
    output logic [NUM_AXES-1:0][TW-1:0]         o_cos
);

    localparam int SH = Q30_BITS - TRIG_FRAC_BITS;
    localparam logic [Q30_BITS+1:0] HALF = (SH > 0) ? ((Q30_BITS + 2)'(1) << (SH - 1)) : '0;
    localparam logic [TW-1:0] ONE = TW'(1) << TRIG_FRAC_BITS;

    logic [NUM_AXES-1:0]         r_en;
    logic [NUM_AXES-1:0][TW-1:0] r_sin;
    logic [NUM_AXES-1:0][TW-1:0] r_cos;

    logic [ANGLE_WIDTH-1:0] n_deg;
    logic [6:0]             n_rem;
    logic [1:0]             n_quad;
    logic [Q30_BITS:0]      n_s30;
    logic [Q30_BITS:0]      n_c30;
    logic [TW-1:0]          n_smag;
    logic [TW-1:0]          n_cmag;
    logic [TW-1:0]          n_sin;
    logic [TW-1:0]          n_cos;

    // Rounds a Q1.30 magnitude half up to the trig format.
    function automatic logic [TW-1:0] round_trig(input logic [Q30_BITS:0] q30);
        logic [Q30_BITS+1:0] t;
        t = ((Q30_BITS + 2)'(q30) + HALF) >> SH;
        return t[TW-1:0];
    endfunction

    // One trig lookup serves whichever angle register is being written.
    always_comb begin
        n_deg = (i_cfg_data >= ANGLE_WIDTH'(360)) ? (i_cfg_data - ANGLE_WIDTH'(360))
                                                    : i_cfg_data;
        if (n_deg < ANGLE_WIDTH'(90)) begin
            n_quad = 2'd0;
            n_rem  = n_deg[6:0];
        end else if (n_deg < ANGLE_WIDTH'(180)) begin
            n_quad = 2'd1;
            n_rem  = 7'(n_deg - ANGLE_WIDTH'(90));
        end else if (n_deg < ANGLE_WIDTH'(270)) begin
            n_quad = 2'd2;
            n_rem  = 7'(n_deg - ANGLE_WIDTH'(180));
        end else begin
            n_quad = 2'd3;
            n_rem  = 7'(n_deg - ANGLE_WIDTH'(270));
        end
        n_s30  = SIN_Q30_TAB[n_rem];
        n_c30  = SIN_Q30_TAB[7'(SIN_TAB_LAST) - n_rem];
        n_smag = round_trig(n_s30);
        n_cmag = round_trig(n_c30);
        unique case (n_quad)
            2'd0: begin
                n_sin = n_smag;
                n_cos = n_cmag;
            end
            2'd1: begin
                n_sin = n_cmag;
                n_cos = -n_smag;
            end
            2'd2: begin
                n_sin = -n_smag;
                n_cos = -n_cmag;
            end
            default: begin
                n_sin = -n_cmag;
                n_cos = n_smag;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= '0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_sin[a] <= '0;
                r_cos[a] <= ONE;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_X_ENABLE: r_en[AXIS_X] <= i_cfg_data[0];
                REG_Y_ENABLE: r_en[AXIS_Y] <= i_cfg_data[0];
                REG_Z_ENABLE: r_en[AXIS_Z] <= i_cfg_data[0];
                REG_X_ANGLE: begin
                    r_sin[AXIS_X] <= n_sin;
                    r_cos[AXIS_X] <= n_cos;
                end
                REG_Y_ANGLE: begin
                    r_sin[AXIS_Y] <= n_sin;
                    r_cos[AXIS_Y] <= n_cos;
                end
                REG_Z_ANGLE: begin
                    r_sin[AXIS_Z] <= n_sin;
                    r_cos[AXIS_Z] <= n_cos;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_en        = r_en;
    assign o_sin       = r_sin;
    assign o_cos       = r_cos;

endmodule

// ===== rtl/core/xyzr_rot.sv =====
module xyzr_rot
    import xyzr_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
    localparam int CW = COORD_WIDTH,
    localparam int TW = TRIG_FRAC_BITS + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [CW-1:0] i_u,
    input  logic signed [CW-1:0] i_v,
    input  logic signed [CW-1:0] i_w,
    input  logic                 i_en,
    input  logic signed [TW-1:0] i_sin,
    input  logic signed [TW-1:0] i_cos,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [CW-1:0] o_u,
    output logic signed [CW-1:0] o_v,
    output logic signed [CW-1:0] o_w
);

    // u' = u*c - v*s and v' = u*s + v*c; w passes through.
    localparam int PW = CW + TW;
    localparam int AW = PW + 1;
    localparam logic signed [AW-1:0] HALF   = AW'(1) <<< (TRIG_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] SATMAX = AW'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic signed [AW-1:0] SATMIN = -SATMAX - AW'(1);

    logic                 r1_vld;
    logic signed [PW-1:0] r1_uc, r1_vs, r1_us, r1_vc;
    logic signed [CW-1:0] r1_u, r1_v, r1_w;
    logic                 r2_vld;
    logic signed [CW-1:0] r2_u, r2_v, r2_w;
    logic                 w_rdy1, w_rdy2;
    logic signed [AW-1:0] n_a, n_b;

    function automatic logic signed [CW-1:0] sat(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] t;
        t = v >>> TRIG_FRAC_BITS;
        if (t > SATMAX) begin
            return SATMAX[CW-1:0];
        end else if (t < SATMIN) begin
            return SATMIN[CW-1:0];
        end
        return t[CW-1:0];
    endfunction

    assign w_rdy2  = !r2_vld || i_ready;
    assign w_rdy1  = !r1_vld || w_rdy2;
    assign o_ready = w_rdy1;

    always_comb begin
        n_a = AW'(r1_uc) - AW'(r1_vs) + HALF;
        n_b = AW'(r1_us) + AW'(r1_vc) + HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r1_vld <= i_valid;
            end
            if (w_rdy2) begin
                r2_vld <= r1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_uc <= PW'(i_u) * PW'(i_cos);
            r1_vs <= PW'(i_v) * PW'(i_sin);
            r1_us <= PW'(i_u) * PW'(i_sin);
            r1_vc <= PW'(i_v) * PW'(i_cos);
            r1_u  <= i_u;
            r1_v  <= i_v;
            r1_w  <= i_w;
        end
        if (w_rdy2 && r1_vld) begin
            r2_u <= i_en ? sat(n_a) : r1_u;
            r2_v <= i_en ? sat(n_b) : r1_v;
            r2_w <= r1_w;
        end
    end

    assign o_valid = r2_vld;
    assign o_u     = r2_u;
    assign o_v     = r2_v;
    assign o_w     = r2_w;

endmodule

// ===== rtl/core/xyz_euler_vertex_rotate.sv =====
// Euler X-Y-Z vertex rotation.
// A vertex word (vx, vy, vz, signed fixed point) enters on the slave stream and is
// rotated about X, then Y, then Z by the angles held in the configuration registers.
// Each axis has its own enable; a disabled axis passes its coordinates unchanged.
// Products are rounded half up and each coordinate saturates to the signed range.
// The configuration channel writes one register per handshake: indexes 0..2 are the
// X, Y and Z enables, 3..5 the angles in whole degrees (values of 360 and up wrap).
// Sine and cosine are looked up when an angle is written, so they are ready at once.
// Writes to indexes past the list are ignored. Write configuration only while idle.
// Throughput is one vertex per clock while the master side keeps ready high;
// each of the three rotation units has a multiply stage and a round and saturate
// stage. Every stage has its own valid bit and accepts a word whenever it is empty
// or its contents move on, so the input keeps flowing into bubbles while the master
// side is stalled; nothing is dropped or repeated under back pressure.
// Reset clears all enables and angles to zero and empties the pipeline.
module xyz_euler_vertex_rotate
    import xyzr_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
    localparam int CW  = COORD_WIDTH,
    localparam int TW  = TRIG_FRAC_BITS + 2,
    localparam int DW  = ((3 * CW + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [DW-1:0]              i_s_tdata,   // vx, vy, vz from the lowest bit up
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [DW-1:0]              o_m_tdata    // rx, ry, rz from the lowest bit up
);

    logic [NUM_AXES-1:0]         w_en;
    logic [NUM_AXES-1:0][TW-1:0] w_sin;
    logic [NUM_AXES-1:0][TW-1:0] w_cos;

    logic signed [CW-1:0] w_vx, w_vy, w_vz;
    logic                 w_x_vld, w_x_rdy, w_y_vld, w_y_rdy;
    logic signed [CW-1:0] w_x_u, w_x_v, w_x_w;
    logic signed [CW-1:0] w_y_u, w_y_v, w_y_w;
    logic signed [CW-1:0] w_z_u, w_z_v, w_z_w;

    xyzr_cfg #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_en       (w_en),
        .o_sin      (w_sin),
        .o_cos      (w_cos)
    );

    assign w_vx = i_s_tdata[CW-1:0];
    assign w_vy = i_s_tdata[2*CW-1:CW];
    assign w_vz = i_s_tdata[3*CW-1:2*CW];

    // About X: u = y, v = z; the unit returns y' and z', with x passed along.
    xyzr_rot #(
        .COORD_WIDTH   (COORD_WIDTH),
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_rot_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_s_tvalid),
        .o_ready(o_s_tready),
        .i_u    (w_vy),
        .i_v    (w_vz),
        .i_w    (w_vx),
        .i_en   (w_en[AXIS_X]),
        .i_sin  (w_sin[AXIS_X]),
        .i_cos  (w_cos[AXIS_X]),
        .o_valid(w_x_vld),
        .i_ready(w_x_rdy),
        .o_u    (w_x_u),
        .o_v    (w_x_v),
        .o_w    (w_x_w)
    );

    // About Y: u = z, v = x gives z' = z*c - x*s and x' = z*s + x*c.
    xyzr_rot #(
        .COORD_WIDTH   (COORD_WIDTH),
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_rot_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_x_vld),
        .o_ready(w_x_rdy),
        .i_u    (w_x_v),
        .i_v    (w_x_w),
        .i_w    (w_x_u),
        .i_en   (w_en[AXIS_Y]),
        .i_sin  (w_sin[AXIS_Y]),
        .i_cos  (w_cos[AXIS_Y]),
        .o_valid(w_y_vld),
        .i_ready(w_y_rdy),
        .o_u    (w_y_u),
        .o_v    (w_y_v),
        .o_w    (w_y_w)
    );

    // About Z: u = x, v = y; z passes along.
    xyzr_rot #(
        .COORD_WIDTH   (COORD_WIDTH),
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_rot_z (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_y_vld),
        .o_ready(w_y_rdy),
        .i_u    (w_y_v),
        .i_v    (w_y_w),
        .i_w    (w_y_u),
        .i_en   (w_en[AXIS_Z]),
        .i_sin  (w_sin[AXIS_Z]),
        .i_cos  (w_cos[AXIS_Z]),
        .o_valid(o_m_tvalid),
        .i_ready(i_m_tready),
        .o_u    (w_z_u),
        .o_v    (w_z_v),
        .o_w    (w_z_w)
    );

    assign o_m_tdata = DW'({w_z_w, w_z_v, w_z_u});

endmodule

// ===== verif/xyz_euler_vertex_rotate_chk.sv =====
`timescale 1ns / 1ps

module xyz_euler_vertex_rotate_chk
    import xyzr_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    input  logic [47:0]                i_s_tdata,   // vx, vy, vz from the lowest bit up
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    input  logic [47:0]                i_m_tdata,   // rx, ry, rz from the lowest bit up
    output int                         o_failures,
    output int                         o_pending,
    output int                         o_checked
);

    localparam int CW = COORD_WIDTH_DEF;
    localparam int TF = TRIG_FRAC_BITS_DEF;
    localparam longint COORD_HI = (longint'(1) << (CW - 1)) - 1;
    localparam longint COORD_LO = -COORD_HI - 1;

    // The first member sits in the highest bits, so x lands in the lowest field.
    typedef struct packed {
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
    } t_vertex;

    int       sine_deg [0:359];
    int       cosine_deg [0:359];
    logic     axis_on [NUM_AXES];
    logic [ANGLE_WIDTH-1:0] axis_deg [NUM_AXES];
    t_vertex  rotated_q [$];
    int       failures;
    int       checked;

    // Sine of 0..90 degrees in Q1.30 from a truncating Taylor series.
    function automatic logic [63:0] quarter_sine_q30(input int unsigned deg);
        logic [63:0] ang;
        logic [63:0] term;
        longint      acc;
        int          k;
        logic        done;
        ang  = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
        term = ang;
        acc  = longint'(ang);
        k    = 1;
        done = 1'b0;
        while (k <= 12 && !done) begin
            term = ((term * ang) >> 30) * ang >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (term == 64'd0) begin
                done = 1'b1;
            end else if ((k % 2) == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
            k++;
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > (longint'(1) << 30)) begin
            acc = longint'(1) << 30;
        end
        return 64'(acc);
    endfunction

    // Round the magnitude half up to the trig fraction width, then apply the sign.
    function automatic int q30_to_trig(input logic [63:0] mag, input logic neg);
        logic [63:0] m;
        m = (mag + (64'd1 << (29 - TF))) >> (30 - TF);
        return neg ? -int'(m) : int'(m);
    endfunction

    // a*p + b*q back to coordinate format, rounded half up and saturated.
    function automatic logic signed [CW-1:0] mix_round(input longint a, input longint p,
                                                      input longint b, input longint q);
        longint acc;
        acc = a * p + b * q + (longint'(1) << (TF - 1));
        acc = acc >>> TF;
        if (acc > COORD_HI) begin
            acc = COORD_HI;
        end else if (acc < COORD_LO) begin
            acc = COORD_LO;
        end
        return CW'(acc);
    endfunction

    function automatic t_vertex rotate_vertex(input t_vertex v);
        longint  x;
        longint  y;
        longint  z;
        longint  nx;
        longint  ny;
        longint  nz;
        int      s;
        int      c;
        t_vertex r;
        x = v.x;
        y = v.y;
        z = v.z;
        if (axis_on[AXIS_X]) begin
            s  = sine_deg[axis_deg[AXIS_X] % 360];
            c  = cosine_deg[axis_deg[AXIS_X] % 360];
            ny = mix_round(y, c, z, -s);
            nz = mix_round(y, s, z, c);
            y  = ny;
            z  = nz;
        end
        if (axis_on[AXIS_Y]) begin
            s  = sine_deg[axis_deg[AXIS_Y] % 360];
            c  = cosine_deg[axis_deg[AXIS_Y] % 360];
            nx = mix_round(x, c, z, s);
            nz = mix_round(z, c, x, -s);
            x  = nx;
            z  = nz;
        end
        if (axis_on[AXIS_Z]) begin
            s  = sine_deg[axis_deg[AXIS_Z] % 360];
            c  = cosine_deg[axis_deg[AXIS_Z] % 360];
            nx = mix_round(x, c, y, -s);
            ny = mix_round(x, s, y, c);
            x  = nx;
            y  = ny;
        end
        r.x = x[CW-1:0];
        r.y = y[CW-1:0];
        r.z = z[CW-1:0];
        return r;
    endfunction

    task automatic report_field(input string name, input logic signed [CW-1:0] want,
                                input logic signed [CW-1:0] got);
        if (got !== want) begin
            failures++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    initial begin
        logic [63:0] s;
        logic [63:0] c;
        failures = 0;
        checked  = 0;
        for (int d = 0; d < 360; d++) begin
            s = quarter_sine_q30(d % 90);
            c = quarter_sine_q30(90 - d % 90);
            case (d / 90)
                0: begin
                    sine_deg[d] = q30_to_trig(s, 1'b0);
                    cosine_deg[d] = q30_to_trig(c, 1'b0);
                end
                1: begin
                    sine_deg[d] = q30_to_trig(c, 1'b0);
                    cosine_deg[d] = q30_to_trig(s, 1'b1);
                end
                2: begin
                    sine_deg[d] = q30_to_trig(s, 1'b1);
                    cosine_deg[d] = q30_to_trig(c, 1'b1);
                end
                default: begin
                    sine_deg[d] = q30_to_trig(c, 1'b1);
                    cosine_deg[d] = q30_to_trig(s, 1'b0);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_vertex got;
        t_vertex want;
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                axis_on[a]  = 1'b0;
                axis_deg[a] = '0;
            end
            rotated_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_X_ENABLE: axis_on[AXIS_X]  = i_cfg_data[0];
                    REG_Y_ENABLE: axis_on[AXIS_Y]  = i_cfg_data[0];
                    REG_Z_ENABLE: axis_on[AXIS_Z]  = i_cfg_data[0];
                    REG_X_ANGLE:  axis_deg[AXIS_X] = i_cfg_data[ANGLE_WIDTH-1:0];
                    REG_Y_ANGLE:  axis_deg[AXIS_Y] = i_cfg_data[ANGLE_WIDTH-1:0];
                    REG_Z_ANGLE:  axis_deg[AXIS_Z] = i_cfg_data[ANGLE_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (rotated_q.size() == 0) begin
                    failures++;
                    $display("%0t ns: result word with none expected, expected none, actual %h",
                             $time, got);
                end else begin
                    want = rotated_q.pop_front();
                    checked++;
                    report_field("rx", want.x, got.x);
                    report_field("ry", want.y, got.y);
                    report_field("rz", want.z, got.z);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                rotated_q.push_back(rotate_vertex(i_s_tdata));
            end
        end
        o_pending  <= rotated_q.size();
        o_failures <= failures;
        o_checked  <= checked;
    end

endmodule

// ===== verif/xyz_euler_vertex_rotate_tb.sv =====
`timescale 1ns / 1ps

module xyz_euler_vertex_rotate_tb;
    import xyzr_pkg::*;

    localparam int DW = 48;
    // Generous bound on the run.
    localparam int CYCLE_LIMIT = 200000;
    // Indexes past the register list. Writes to them must leave every register alone.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_7 = 3'd7;
    localparam logic [15:0] COORD_MAX = 16'h7FFF;
    localparam logic [15:0] COORD_MIN = 16'h8000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       cfg_valid;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;
    logic                       s_tvalid;
    logic [DW-1:0]              s_tdata;
    logic                       m_tready = 1'b0;
    logic                       o_cfg_ready;
    logic                       o_s_tready;
    logic                       o_m_tvalid;
    logic [DW-1:0]              o_m_tdata;

    int idle_pct = 0;
    int stall_pct = 0;
    int failures;
    int pending;
    int checked;
    int sent = 0;
    int settings = 0;
    int cycle_count = 0;

    // The clock runs with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    xyz_euler_vertex_rotate u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // The checker watches all three channels, predicts each rotated vertex and
    // compares it with what comes out. This module only makes stimulus.
    xyz_euler_vertex_rotate_chk u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (o_m_tdata),
        .o_failures  (failures),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // The receiver drops ready at random, at the rate set by the current phase.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // A hung pipeline ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Most coordinates are uniform over the whole range; the rest sit at the
    // saturation limits or close to zero, where rounding is most visible.
    function automatic logic [15:0] random_coord();
        case ($urandom_range(9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return 16'($urandom_range(32) - 16);
            default: return 16'($urandom());
        endcase
    endfunction

    // Angles favor the quadrant boundaries and the values that wrap past 359.
    function automatic logic [8:0] random_angle();
        case ($urandom_range(7))
            0: return 9'd0;
            1: return 9'd359;
            2: return 9'(90 * $urandom_range(3));
            3: return 9'($urandom_range(511, 360));
            default: return 9'($urandom_range(359));
        endcase
    endfunction

    // Offers one configuration word and holds it until the block takes it.
    // The caller lowers valid once the whole batch is written.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Stops the sender and waits until every expected result has come out,
    // then waits out the requested settle time when asked to.
    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    // Writes all six registers while the pipeline is empty. Only bit 0 of an
    // enable word counts, so callers may put junk in the upper bits. A write to
    // an index past the list follows, and must change nothing.
    task automatic apply_rotation(input logic [8:0] x_en, input logic [8:0] y_en,
                                  input logic [8:0] z_en, input logic [8:0] x_ang,
                                  input logic [8:0] y_ang, input logic [8:0] z_ang);
        drain_results(0);
        write_reg(REG_X_ENABLE, x_en);
        write_reg(REG_Y_ENABLE, y_en);
        write_reg(REG_Z_ENABLE, z_en);
        write_reg(REG_X_ANGLE, x_ang);
        write_reg(REG_Y_ANGLE, y_ang);
        write_reg(REG_Z_ANGLE, z_ang);
        write_reg($urandom_range(1) ? REG_UNUSED_7 : REG_UNUSED_6, 9'($urandom()));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Offers one vertex word, after a random gap, and waits for the handshake.
    // Valid stays high afterwards so that back-to-back words need no toggle.
    task automatic send_vertex(input logic [15:0] vx, input logic [15:0] vy,
                               input logic [15:0] vz);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vz, vy, vx};
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        sent++;
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: one setting per rotation alone, all off, all on across
        // the quadrant boundaries, and one setting that wraps angles past 359 and
        // puts junk above bit 0 of the enables. Each setting sees the corner
        // vertices, which also drive the saturation paths.
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: apply_rotation(9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
                1: apply_rotation(9'd1, 9'd0, 9'd0, 9'd90, 9'd0, 9'd0);
                2: apply_rotation(9'd0, 9'd1, 9'd0, 9'd0, 9'd45, 9'd0);
                3: apply_rotation(9'd0, 9'd0, 9'd1, 9'd0, 9'd0, 9'd359);
                4: apply_rotation(9'd1, 9'd1, 9'd1, 9'd180, 9'd270, 9'd45);
                default: apply_rotation(9'h1FE, 9'h003, 9'h0FF, 9'd511, 9'd360, 9'd450);
            endcase
            for (int j = 0; j < 4; j++) begin
                case (j)
                    0: send_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
                    1: send_vertex(COORD_MIN, COORD_MIN, COORD_MIN);
                    2: send_vertex(COORD_MAX, COORD_MIN, 16'h0001);
                    default: send_vertex(16'hFFFF, 16'h0000, COORD_MIN);
                endcase
            end
        end

        // Random part: each phase gets a fresh setting and its own idling mode,
        // cycling through no idling, a sparse sender, a stalling receiver and both.
        for (int p = 0; p < 11; p++) begin
            case (p % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 58;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 58;
                end
                default: begin
                    idle_pct  = 27;
                    stall_pct = 27;
                end
            endcase
            // Enables lean toward on so that most words pass through several
            // rotations; the upper bits of each enable word are random.
            apply_rotation({8'($urandom()), 1'($urandom_range(3) != 0)},
                           {8'($urandom()), 1'($urandom_range(3) != 0)},
                           {8'($urandom()), 1'($urandom_range(3) != 0)},
                           random_angle(), random_angle(), random_angle());
            for (int i = 0; i < 50; i++) begin
                // Now and then the sender holds off until the pipeline runs dry.
                if ((p % 3) == 1 && i == 25) begin
                    drain_results(0);
                end
                send_vertex(random_coord(), random_coord(), random_coord());
            end
        end

        // Wait for the last results, then a little longer to catch any extra word.
        drain_results(20);

        $display("summary: %0d vertex words over %0d register settings, %0d results checked",
                 sent, settings, checked);
        $display("summary: single axes, all axes, wrapped angles, ignored indexes, saturation");
        if (failures == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
